@@ hw/rtl/mshw_pkg.sv @@
// Shared types, constants and codes for the multi-slot heartbeat watchdog.
// Used by the slot cell, the top level and the port checker.
package mshw_pkg;

    localparam int SLOTS       = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_REPORTS = 16;

    localparam logic [15:0] SWEEP_RESET = 16'd1000;

    localparam logic [2:0] ACT_REG_STALL    = 3'd0;
    localparam logic [2:0] ACT_REG_PERIODIC = 3'd1;
    localparam logic [2:0] ACT_HEARTBEAT    = 3'd2;
    localparam logic [2:0] ACT_UNREGISTER   = 3'd3;
    localparam logic [2:0] ACT_TICK         = 3'd4;
    localparam logic [2:0] ACT_QUERY        = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_ARG = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [31:0] period;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_slot;
        logic        fire;
        logic [47:0] fire_beat_time;
        logic [47:0] age;
        logic [31:0] deadline_out;
        logic [15:0] fire_total;
        logic        is_periodic;
        logic        stalled_now;
        logic        is_active;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic             active;
        logic             periodic;
        logic [31:0]      deadline;
        logic [47:0]      last_beat;
        logic             armed;
        logic [15:0]      count;
        logic [IDX_W-1:0] idx;
    } t_rec;

endpackage

@@ hw/rtl/multi_slot_heartbeat_watchdog_core.sv @@
// Top level of the multi-slot heartbeat watchdog: a ring of slot cells and its controller.
// Depends on mshw_pkg and mshw_cell.
//
// Usage: commands arrive on the input channel (i_in_valid, o_in_stall, i_in_item) and
// results leave on the output channel (o_out_valid, i_out_stall, o_out_item). The
// sweep_interval register is written through i_cfg_valid, o_cfg_ready and i_cfg_data;
// a value of zero is stored as one.
// The slot records circulate through a ring of SLOTS cells. Each accepted item rotates
// the ring once, one slot per cycle unless the output stalls, starting with slot zero,
// and the controller updates the record at the head.
// The last result of an item is loaded once the ring has rotated through every slot and
// the controller has moved from S_RUN to S_FIN; output stalls can delay it. The next item
// is accepted the cycle after that last result is loaded, so items never overlap.
// A tick that sweeps emits one result per firing slot, in slot order, followed by a
// closing result with last set; every other item emits a single result with last set.
// While i_out_stall is high and a result is waiting, the ring holds still.
// Reset clears time, the sweep countdown and every slot's active flag.
module multi_slot_heartbeat_watchdog_core import mshw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state;
    logic [IDX_W-1:0] r_cnt;
    logic [47:0]      r_now;
    logic [15:0]      r_cd;
    logic [15:0]      r_int;
    logic             r_sweep;
    logic             r_found;
    logic [4:0]       r_nrep;
    logic [2:0]       r_act;
    logic [3:0]       r_slot;
    logic [31:0]      r_period;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_ov;

    t_rec chain [SLOTS];
    t_rec head;
    t_rec n_rec;
    t_out_item n_res;
    t_out_item n_fire;
    t_out_item n_start;
    t_out_item n_final;
    logic      n_sweep;
    logic      n_ov;
    logic      n_emit;
    logic      n_found;
    logic      step;
    logic      accept;
    logic      avail;
    logic      match;
    logic      due;
    logic      fired;
    logic [47:0] age;
    logic [47:0] when;

    assign head        = chain[SLOTS-1];
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign avail       = !r_ov || !i_out_stall;
    assign step        = (r_state == S_RUN) && avail;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_rec cell_in;
        if (k == 0) begin : g_first
            assign cell_in = n_rec;
        end else begin : g_rest
            assign cell_in = chain[k-1];
        end
        mshw_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (step),
            .i_idx_init (IDX_W'(SLOTS - 1 - k)),
            .i_rec      (cell_in),
            .o_rec      (chain[k])
        );
    end

    always_comb begin
        n_start = '0;
        n_sweep = (i_in_item.action == ACT_TICK) && (r_cd <= 16'd1);
        if (i_in_item.action == ACT_TICK) begin
            n_start = '0;
        end else if (i_in_item.action == ACT_REG_STALL ||
                     i_in_item.action == ACT_REG_PERIODIC) begin
            n_start.status = (i_in_item.period == 32'd0) ? ST_BAD_ARG : ST_FULL;
        end else if (i_in_item.action > ACT_QUERY) begin
            n_start.status = ST_IGNORED;
        end else if ({1'b0, i_in_item.slot} >= 5'(SLOTS)) begin
            n_start.status = ST_IGNORED;
        end else begin
            n_start.result_slot = i_in_item.slot;
        end
        n_final      = r_res;
        n_final.last = 1'b1;
    end

    always_comb begin
        age    = r_now - head.last_beat;
        due    = age >= {16'd0, head.deadline};
        match  = ({5'd0, r_slot} == 9'(head.idx));
        n_rec  = head;
        n_res  = r_res;
        n_fire = '0;
        n_emit = 1'b0;
        n_found = r_found;
        fired  = 1'b0;
        when   = r_now;
        case (r_act)
            ACT_REG_STALL, ACT_REG_PERIODIC: begin
                if (r_period != 32'd0 && !r_found && !head.active) begin
                    n_rec.active    = 1'b1;
                    n_rec.periodic  = (r_act == ACT_REG_PERIODIC);
                    n_rec.deadline  = r_period;
                    n_rec.last_beat = r_now;
                    n_rec.armed     = 1'b1;
                    n_rec.count     = 16'd0;
                    n_found           = 1'b1;
                    n_res.status      = ST_OK;
                    n_res.result_slot = 4'(head.idx);
                    n_res.deadline_out = r_period;
                    n_res.is_periodic = (r_act == ACT_REG_PERIODIC);
                    n_res.is_active   = 1'b1;
                end
            end
            ACT_HEARTBEAT: begin
                if (match) begin
                    if (head.active && !head.periodic) begin
                        n_rec.last_beat = r_now;
                        n_rec.armed     = 1'b1;
                    end else begin
                        n_res.status = ST_IGNORED;
                    end
                end
            end
            ACT_UNREGISTER: begin
                if (match) begin
                    n_rec.active = 1'b0;
                end
            end
            ACT_QUERY: begin
                if (match && head.active) begin
                    n_res.age          = age;
                    n_res.deadline_out = head.deadline;
                    n_res.fire_total   = head.count;
                    n_res.is_periodic  = head.periodic;
                    n_res.stalled_now  = !head.periodic && (age > {16'd0, head.deadline});
                    n_res.is_active    = 1'b1;
                end
            end
            ACT_TICK: begin
                if (r_sweep && head.active && due) begin
                    if (head.periodic) begin
                        n_rec.last_beat = r_now;
                        fired = 1'b1;
                    end else if (head.armed) begin
                        n_rec.armed = 1'b0;
                        when  = head.last_beat;
                        fired = 1'b1;
                    end
                end
                if (fired) begin
                    if (head.count != 16'hFFFF) begin
                        n_rec.count = head.count + 16'd1;
                    end
                    if (r_nrep < 5'(MAX_REPORTS)) begin
                        n_emit = 1'b1;
                        n_fire.result_slot    = 4'(head.idx);
                        n_fire.fire           = 1'b1;
                        n_fire.fire_beat_time = when;
                        n_fire.is_periodic    = head.periodic;
                    end
                end
            end
            default: begin
            end
        endcase
        n_ov = (r_ov && i_out_stall) || (step && n_emit) || ((r_state == S_FIN) && avail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_now   <= 48'd0;
            r_cd    <= 16'd0;
            r_int   <= SWEEP_RESET;
            r_sweep <= 1'b0;
            r_found <= 1'b0;
            r_nrep  <= 5'd0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_int <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            end
            r_ov <= n_ov;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act    <= i_in_item.action;
                        r_slot   <= i_in_item.slot;
                        r_period <= i_in_item.period;
                        r_cnt    <= '0;
                        r_found  <= 1'b0;
                        r_nrep   <= 5'd0;
                        r_sweep  <= n_sweep;
                        r_res    <= n_start;
                        r_state  <= S_RUN;
                        if (i_in_item.action == ACT_TICK) begin
                            r_now <= r_now + 48'd1;
                            if (r_cd <= 16'd1) begin
                                r_cd <= r_int;
                            end else begin
                                r_cd <= r_cd - 16'd1;
                            end
                        end
                    end
                end
                S_RUN: begin
                    if (step) begin
                        r_res   <= n_res;
                        r_found <= n_found;
                        if (n_emit) begin
                            r_out  <= n_fire;
                            r_nrep <= r_nrep + 5'd1;
                        end
                        if (r_cnt == IDX_W'(SLOTS - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (avail) begin
                        r_out   <= n_final;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/mshw_cell.sv @@
// One watchdog slot cell: holds one channel record and passes it on to the next cell.
// Depends on mshw_pkg for the record type.
module mshw_cell import mshw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [IDX_W-1:0] i_idx_init,
    input  t_rec             i_rec,
    output t_rec             o_rec
);

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.active <= 1'b0;
            r_rec.idx    <= i_idx_init;
        end else if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

@@ hw/rtl/mshw_checker.sv @@
// Port-level checker for the multi-slot heartbeat watchdog, bound to the top level.
// Depends on mshw_pkg and multi_slot_heartbeat_watchdog_core.
module mshw_port_props import mshw_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input was not stalled after an item was accepted.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("Stalled result changed or vanished.");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && o_out_valid) |-> o_out_item.last)
        else $error("Block is idle while a result that is not last is pending.");

    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.fire) |-> !o_out_item.last)
        else $error("Fire result marked as last.");

endmodule

bind multi_slot_heartbeat_watchdog_core mshw_port_props u_mshw_port_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ verif/mshw_checker.sv @@
// Checker for the multi-slot heartbeat watchdog: watches the command, result and
// configuration channels, predicts every result and compares it. Depends on mshw_pkg.
module mshw_checker import mshw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int        o_errors,
    output int        o_pending
);

    logic [15:0] interval;
    logic [47:0] now_ticks;
    logic [15:0] countdown;
    logic        act [SLOTS];
    logic        per [SLOTS];
    logic [31:0] dl [SLOTS];
    logic [47:0] beat [SLOTS];
    logic        armed [SLOTS];
    logic [15:0] fires [SLOTS];
    t_out_item   expected_results[$];

    assign o_pending = expected_results.size();

    function automatic t_out_item blank_result();
        t_out_item r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic run_sweep();
        t_out_item r;
        logic [47:0] age;
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!act[i]) continue;
            age = now_ticks - beat[i];
            if (age < {16'd0, dl[i]}) continue;
            r = '0;
            if (per[i]) begin
                beat[i] = now_ticks;
                r.fire_beat_time = now_ticks;
            end else begin
                if (!armed[i]) continue;
                armed[i] = 1'b0;
                r.fire_beat_time = beat[i];
            end
            if (fires[i] != 16'hFFFF) fires[i]++;
            if (n < MAX_REPORTS) begin
                r.result_slot = i[3:0];
                r.fire = 1'b1;
                r.is_periodic = per[i];
                expected_results.push_back(r);
                n++;
            end
        end
    endtask

    task automatic predict_command(input t_in_item it);
        t_out_item r;
        logic [47:0] age;
        int i;
        r = blank_result();
        if (it.action == ACT_TICK) begin
            now_ticks = now_ticks + 48'd1;
            if (countdown <= 16'd1) begin
                run_sweep();
                countdown = interval;
            end else begin
                countdown--;
            end
        end else if (it.action == ACT_REG_STALL || it.action == ACT_REG_PERIODIC) begin
            if (it.period == 32'd0) begin
                r.status = ST_BAD_ARG;
            end else begin
                for (i = 0; i < SLOTS; i++) if (!act[i]) break;
                if (i >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    act[i] = 1'b1;
                    per[i] = (it.action == ACT_REG_PERIODIC);
                    dl[i] = it.period;
                    beat[i] = now_ticks;
                    armed[i] = 1'b1;
                    fires[i] = '0;
                    r.result_slot = i[3:0];
                    r.deadline_out = it.period;
                    r.is_periodic = per[i];
                    r.is_active = 1'b1;
                end
            end
        end else if (it.action > ACT_QUERY) begin
            r.status = ST_IGNORED;
        end else begin
            r.result_slot = it.slot;
            if (it.action == ACT_HEARTBEAT) begin
                if (!act[it.slot] || per[it.slot]) begin
                    r.status = ST_IGNORED;
                end else begin
                    beat[it.slot] = now_ticks;
                    armed[it.slot] = 1'b1;
                end
            end else if (it.action == ACT_UNREGISTER) begin
                act[it.slot] = 1'b0;
            end else if (act[it.slot]) begin
                age = now_ticks - beat[it.slot];
                r.age = age;
                r.deadline_out = dl[it.slot];
                r.fire_total = fires[it.slot];
                r.is_periodic = per[it.slot];
                r.stalled_now = !per[it.slot] && (age > {16'd0, dl[it.slot]});
                r.is_active = 1'b1;
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            interval <= SWEEP_RESET;
            now_ticks <= '0;
            countdown <= '0;
            for (int i = 0; i < SLOTS; i++) act[i] <= 1'b0;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                interval <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            if (i_in_valid && !i_in_stall)
                predict_command(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_item) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, want, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb_multi_slot_heartbeat_watchdog_core.sv @@
// Testbench top for the multi-slot heartbeat watchdog core: clock, reset, commands,
// configuration writes and output stalls. Depends on mshw_pkg and mshw_checker.
module tb_multi_slot_heartbeat_watchdog_core;
    import mshw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          quiet;
    bit          hold_off;

    multi_slot_heartbeat_watchdog_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    mshw_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Output stalls: random bursts, one long hold-off, none once quiet is set.
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_command(input logic [2:0] action, input logic [3:0] slot,
                                input logic [31:0] period);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{action: action, slot: slot, period: period};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_interval(input logic [15:0] value);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_command(ACT_TICK, 4'($urandom), $urandom);
            else if (pick < 55)
                send_command(3'($urandom_range(0, 1)), 4'($urandom),
                             ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
            else if (pick < 68)
                send_command(ACT_HEARTBEAT, 4'($urandom), $urandom);
            else if (pick < 76)
                send_command(ACT_UNREGISTER, 4'($urandom), $urandom);
            else if (pick < 96)
                send_command(ACT_QUERY, 4'($urandom), $urandom);
            else
                send_command(3'($urandom_range(6, 7)), 4'($urandom), $urandom);
        end
    endtask

    initial begin
        quiet = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(ACT_TICK, 4'd0, 32'd0);
        send_command(ACT_REG_STALL, 4'd0, 32'd0);
        send_command(ACT_REG_STALL, 4'd15, 32'hFFFF_FFFF);
        send_command(ACT_REG_PERIODIC, 4'd0, 32'd1);
        send_command(ACT_HEARTBEAT, 4'd1, 32'd0);
        send_command(ACT_HEARTBEAT, 4'd0, 32'd0);
        send_command(ACT_HEARTBEAT, 4'd9, 32'd0);
        send_command(ACT_QUERY, 4'd0, 32'd0);
        send_command(ACT_QUERY, 4'd15, 32'd0);
        send_command(ACT_UNREGISTER, 4'd12, 32'd0);
        send_command(3'd6, 4'd0, 32'd0);
        send_command(3'd7, 4'hF, 32'hFFFF_FFFF);
        for (int k = 0; k < 15; k++)
            send_command(ACT_REG_STALL, 4'd0, 32'd2);

        write_interval(16'd0);
        for (int k = 0; k < 5; k++) send_command(ACT_TICK, 4'd0, 32'd0);
        send_command(ACT_QUERY, 4'd2, 32'd0);
        send_command(ACT_HEARTBEAT, 4'd2, 32'd0);

        hold_off = 1'b1;
        for (int k = 0; k < 6; k++) send_command(ACT_TICK, 4'd0, 32'd0);
        for (int k = 0; k < 16; k++) send_command(ACT_UNREGISTER, 4'(k), 32'd0);

        random_phase(130);
        write_interval(16'd3);
        random_phase(110);
        write_interval(16'hFFFF);
        random_phase(40);
        write_interval(16'd1);
        quiet = 1'b1;
        random_phase(120);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
